FILE: hdl/at_urc_publish_parser_assert.svh
// assertion macros for the parser rtl
`ifndef AT_URC_PUBLISH_PARSER_ASSERT_SVH
`define AT_URC_PUBLISH_PARSER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define AUP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("aup assertion failed");

// next-cycle implication, checked out of reset
`define AUP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("aup assertion failed");

`endif

FILE: hdl/aup_pkg.sv
// types, character codes and helpers for the modem response parser
package aup_pkg;

  typedef enum logic [1:0] {
    OP_BYTE = 2'd0,
    OP_ARM  = 2'd1,
    OP_READ = 2'd2
  } op_e;

  localparam int unsigned NUM_STATES = 12;

  typedef enum logic [NUM_STATES-1:0] {
    ST_NONE      = 12'b0000_0000_0001,
    ST_O         = 12'b0000_0000_0010,
    ST_PLUS      = 12'b0000_0000_0100,
    ST_S         = 12'b0000_0000_1000,
    ST_SM        = 12'b0000_0001_0000,
    ST_SMS       = 12'b0000_0010_0000,
    ST_SMSU      = 12'b0000_0100_0000,
    ST_SMSUB     = 12'b0000_1000_0000,
    ST_HEADER    = 12'b0001_0000_0000,
    ST_TOPIC     = 12'b0010_0000_0000,
    ST_TOPIC_END = 12'b0100_0000_0000,
    ST_MSG       = 12'b1000_0000_0000
  } state_e;

  localparam logic [7:0] CH_O     = 8'h4F;
  localparam logic [7:0] CH_K     = 8'h4B;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_S     = 8'h53;
  localparam logic [7:0] CH_M     = 8'h4D;
  localparam logic [7:0] CH_U     = 8'h55;
  localparam logic [7:0] CH_B     = 8'h42;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_LC_C  = 8'h63;
  localparam logic [7:0] CH_LC_M  = 8'h6D;
  localparam logic [7:0] CH_LC_D  = 8'h64;

  // topic bytes that tell a command topic
  localparam int unsigned TOPIC_CMD_POS = 8;
  localparam int unsigned CMD_LEN       = 3;

  typedef struct packed {
    logic       ok_seen;
    logic       publish_done;
    logic       modem_synced;
    logic       waiting_ok;
    logic       topic_is_cmd;
    logic [7:0] topic_length;
    logic [7:0] message_length;
    logic [3:0] parser_state;
  } status_t;

  function automatic logic [7:0] sat_inc(input logic [7:0] v);
    return (v == 8'hFF) ? v : v + 8'd1;
  endfunction

  // one-hot state to its index
  function automatic logic [3:0] state_code(input state_e s);
    logic [3:0] code;
    code = '0;
    for (int i = 0; i < NUM_STATES; i++) begin
      if (s[i]) code = code | 4'(i);
    end
    return code;
  endfunction

endpackage

FILE: hdl/aup_in_if.sv
// input channel: op, received byte and read index
interface aup_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [7:0] rx_char;
  logic [4:0] read_index;

  modport source (output valid, output op, output rx_char, output read_index, input ready);
  modport sink (input valid, input op, input rx_char, input read_index, output ready);
endinterface

FILE: hdl/aup_out_if.sv
// result channel: status flags, latched lengths and read byte
interface aup_out_if;
  logic       valid;
  logic       ready;
  logic       ok_seen;
  logic       publish_done;
  logic       modem_synced;
  logic       waiting_ok;
  logic       topic_is_cmd;
  logic [7:0] topic_length;
  logic [7:0] message_length;
  logic [7:0] read_char;
  logic [3:0] parser_state;

  modport source (
    output valid, output ok_seen, output publish_done, output modem_synced,
    output waiting_ok, output topic_is_cmd, output topic_length,
    output message_length, output read_char, output parser_state, input ready
  );
  modport sink (
    input valid, input ok_seen, input publish_done, input modem_synced,
    input waiting_ok, input topic_is_cmd, input topic_length,
    input message_length, input read_char, input parser_state, output ready
  );
endinterface

FILE: hdl/aup_ram.sv
// generic single-write, single-read ram with registered read
module aup_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    if (re_i) rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/aup_matcher.sv
// token matcher, capture counters, latched lengths and flags
module aup_matcher #(
  parameter int unsigned STORE_DEPTH = 32,
  localparam int unsigned AW = $clog2(STORE_DEPTH),
  localparam int unsigned FW = $clog2(STORE_DEPTH + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic [1:0]       op_i,
  input  logic [7:0]       char_i,
  output aup_pkg::status_t status_o,
  output logic             wr_en_o,
  output logic [AW-1:0]    wr_addr_o,
  output logic [7:0]       wr_data_o,
  output logic [FW-1:0]    fill_o
);
  import aup_pkg::*;

  state_e        state_q, state_d;
  logic [7:0]    topic_cnt_q, topic_cnt_d;
  logic [7:0]    msg_cnt_q, msg_cnt_d;
  logic [7:0]    topic_lat_q, topic_lat_d;
  logic [7:0]    msg_len_q, msg_len_d;
  logic          sync_q, sync_d;
  logic          wait_q, wait_d;
  logic [7:0]    cmd_q [CMD_LEN];
  logic [7:0]    cmd_d [CMD_LEN];
  logic [FW-1:0] fill_q, fill_d;
  logic          ok, pub, wr_en;
  logic          byte_step;
  logic [8:0]    cnt_wide, slot;
  logic [7:0]    topic_ofs;

  assign byte_step = step_i && (op_i == OP_BYTE);

  // message slot, overflow lands on the last entry
  assign cnt_wide  = {1'b0, msg_cnt_q};
  assign slot      = (cnt_wide >= 9'(STORE_DEPTH)) ? 9'(STORE_DEPTH - 1) : cnt_wide;
  assign topic_ofs = topic_cnt_q - 8'(TOPIC_CMD_POS);

  always_comb begin
    state_d     = state_q;
    topic_cnt_d = topic_cnt_q;
    msg_cnt_d   = msg_cnt_q;
    topic_lat_d = topic_lat_q;
    msg_len_d   = msg_len_q;
    sync_d      = sync_q;
    wait_d      = wait_q;
    cmd_d       = cmd_q;
    fill_d      = fill_q;
    ok          = 1'b0;
    pub         = 1'b0;
    wr_en       = 1'b0;
    if (byte_step) begin
      state_d = ST_NONE;
      unique case (state_q)
        ST_NONE: begin
          if (char_i == CH_O) state_d = ST_O;
          else if (char_i == CH_PLUS) state_d = ST_PLUS;
        end
        ST_O: begin
          if (char_i == CH_K) ok = 1'b1;
        end
        ST_PLUS:  if (char_i == CH_S) state_d = ST_S;
        ST_S:     if (char_i == CH_M) state_d = ST_SM;
        ST_SM:    if (char_i == CH_S) state_d = ST_SMS;
        ST_SMS:   if (char_i == CH_U) state_d = ST_SMSU;
        ST_SMSU:  if (char_i == CH_B) state_d = ST_SMSUB;
        ST_SMSUB: if (char_i == CH_COLON) state_d = ST_HEADER;
        ST_HEADER: begin
          if (char_i == CH_QUOTE) begin
            state_d     = ST_TOPIC;
            topic_cnt_d = '0;
            msg_cnt_d   = '0;
          end else begin
            state_d = ST_HEADER;
          end
        end
        ST_TOPIC: begin
          if (char_i == CH_QUOTE) begin
            state_d = ST_TOPIC_END;
          end else begin
            // only the command bytes of the topic are ever stored
            if (topic_ofs < 8'(CMD_LEN)) cmd_d[topic_ofs[1:0]] = char_i;
            topic_cnt_d = sat_inc(topic_cnt_q);
            state_d     = ST_TOPIC;
          end
        end
        ST_TOPIC_END: begin
          state_d = (char_i == CH_QUOTE) ? ST_MSG : ST_TOPIC_END;
        end
        ST_MSG: begin
          if (char_i == CH_QUOTE) begin
            topic_lat_d = topic_cnt_q;
            msg_len_d   = msg_cnt_q;
            pub         = 1'b1;
          end else begin
            wr_en     = 1'b1;
            msg_cnt_d = sat_inc(msg_cnt_q);
            if (9'(fill_q) <= slot) fill_d = FW'(slot + 9'd1);
            state_d = ST_MSG;
          end
        end
        default: state_d = ST_NONE;
      endcase
      if (ok) begin
        sync_d = 1'b1;
        wait_d = 1'b0;
      end
    end else if (step_i && (op_i == OP_ARM)) begin
      wait_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_NONE;
      topic_cnt_q <= '0;
      msg_cnt_q   <= '0;
      topic_lat_q <= '0;
      msg_len_q   <= '0;
      sync_q      <= 1'b0;
      wait_q      <= 1'b0;
      fill_q      <= '0;
      for (int i = 0; i < CMD_LEN; i++) cmd_q[i] <= '0;
    end else begin
      state_q     <= state_d;
      topic_cnt_q <= topic_cnt_d;
      msg_cnt_q   <= msg_cnt_d;
      topic_lat_q <= topic_lat_d;
      msg_len_q   <= msg_len_d;
      sync_q      <= sync_d;
      wait_q      <= wait_d;
      fill_q      <= fill_d;
      cmd_q       <= cmd_d;
    end
  end

  always_comb begin
    status_o.ok_seen        = ok;
    status_o.publish_done   = pub;
    status_o.modem_synced   = sync_d;
    status_o.waiting_ok     = wait_d;
    status_o.topic_is_cmd   = (cmd_d[0] == CH_LC_C) && (cmd_d[1] == CH_LC_M) &&
                              (cmd_d[2] == CH_LC_D);
    status_o.topic_length   = topic_lat_d;
    status_o.message_length = msg_len_d;
    status_o.parser_state   = state_code(state_d);
  end

  assign wr_en_o   = wr_en;
  assign wr_addr_o = slot[AW-1:0];
  assign wr_data_o = char_i;
  assign fill_o    = fill_q;

endmodule

FILE: hdl/at_urc_publish_parser.sv
// top level of the modem response parser: input stage, matcher, message ram, result stage
//
//   channel | dir | carries
//   --------+-----+--------------------------------------------------------------
//   in_i    | in  | op, rx_char, read_index
//   out_o   | out | ok_seen, publish_done, flags, lengths, read_char, parser_state
//
// one item per cycle sustained while results are taken; each item passes through the input
// stage and then sits in the result stage until taken
// the message ram has one write and one registered read port, so a read and a write
// never meet in the same cycle (an item does one or the other)
// reset clears matcher, counters, flags and pipeline valids; the ram needs no clearing
// pass since a fill mark makes never-written entries read as zero
// a stalled result holds both stages; the input stage takes a new transfer as soon as
// its content moves on
module at_urc_publish_parser #(
  parameter int unsigned STORE_DEPTH = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  aup_in_if.sink       in_i,
  aup_out_if.source    out_o
);
  import aup_pkg::*;

`include "at_urc_publish_parser_assert.svh"

  localparam int unsigned AW  = $clog2(STORE_DEPTH);
  localparam int unsigned FW  = $clog2(STORE_DEPTH + 1);
  localparam int unsigned IXW = (AW > 5) ? AW : 5;

  // input stage
  logic       in_valid_q, in_valid_d;
  logic [1:0] in_op_q;
  logic [7:0] in_ch_q;
  logic [4:0] in_idx_q;

  // result stage
  logic       out_valid_q, out_valid_d;
  status_t    status_q;
  logic       rd_sel_q;

  logic          accept, advance;
  status_t       status;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;
  logic [FW-1:0] fill;
  logic          rd_sel;
  logic [IXW-1:0] idx_wide;
  logic [7:0]    rdata;

  // the input stage moves on when the result stage is free or being emptied
  assign advance    = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || advance;
  assign accept     = in_i.valid && in_i.ready;

  always_comb begin
    in_valid_d = in_valid_q;
    if (accept) in_valid_d = 1'b1;
    else if (advance) in_valid_d = 1'b0;
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) out_valid_d = 1'b1;
    else if (out_o.ready) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_op_q  <= in_i.op;
      in_ch_q  <= in_i.rx_char;
      in_idx_q <= in_i.read_index;
    end
    if (advance) begin
      status_q <= status;
      rd_sel_q <= rd_sel;
    end
  end

  // matcher state advances only when the item moves into the result stage
  aup_matcher #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_matcher (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (advance),
    .op_i      (in_op_q),
    .char_i    (in_ch_q),
    .status_o  (status),
    .wr_en_o   (wr_en),
    .wr_addr_o (wr_addr),
    .wr_data_o (wr_data),
    .fill_o    (fill)
  );

  // a read hits only entries below the fill mark; the rest read as zero,
  // which also covers an index beyond the store
  assign rd_sel   = (in_op_q == OP_READ) && (9'(in_idx_q) < 9'(fill));
  assign idx_wide = IXW'(in_idx_q);

  aup_ram #(
    .WIDTH (8),
    .DEPTH (STORE_DEPTH)
  ) u_msg_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (wr_data),
    .re_i    (advance && rd_sel),
    .raddr_i (idx_wide[AW-1:0]),
    .rdata_o (rdata)
  );

  assign out_o.valid          = out_valid_q;
  assign out_o.ok_seen        = status_q.ok_seen;
  assign out_o.publish_done   = status_q.publish_done;
  assign out_o.modem_synced   = status_q.modem_synced;
  assign out_o.waiting_ok     = status_q.waiting_ok;
  assign out_o.topic_is_cmd   = status_q.topic_is_cmd;
  assign out_o.topic_length   = status_q.topic_length;
  assign out_o.message_length = status_q.message_length;
  assign out_o.read_char      = rd_sel_q ? rdata : 8'h00;
  assign out_o.parser_state   = status_q.parser_state;

  // a closing quote always drops the matcher back to idle
  `AUP_ASSERT_NOW(a_pub_idle, clk_i, rst_ni, out_valid_q && status_q.publish_done, status_q.parser_state == state_code(ST_NONE))
  // an ok token leaves the block synced and no longer waiting
  `AUP_ASSERT_NOW(a_ok_flags, clk_i, rst_ni, out_valid_q && status_q.ok_seen, status_q.modem_synced && !status_q.waiting_ok)
  // a blocked input stage keeps its item
  `AUP_ASSERT_NEXT(a_in_hold, clk_i, rst_ni, in_valid_q && !advance, in_valid_q && $stable(in_ch_q) && $stable(in_op_q))
  // a ram read is only taken from written entries
  `AUP_ASSERT_NOW(a_rd_filled, clk_i, rst_ni, out_valid_q && rd_sel_q, fill != '0)

endmodule
